// ===== hw/rtl/battery_supervisor_top_assert.svh =====
// assertion macros shared by the battery supervisor rtl
`ifndef BATTERY_SUPERVISOR_TOP_ASSERT_SVH
`define BATTERY_SUPERVISOR_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BSUP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define BSUP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/bsup_pkg.sv =====
// package: types, constants and table of the battery supervisor
`timescale 1ns / 1ps
`default_nettype none

package bsup_pkg;

    // register map
    localparam int          CFG_IDX_W        = 3;
    localparam int          CFG_DATA_W       = 16;
    localparam logic [2:0]  REG_SCALE_NUM    = 3'd0;
    localparam logic [2:0]  REG_SCALE_DEN    = 3'd1;
    localparam logic [2:0]  REG_CHARGE_START = 3'd2;
    localparam logic [2:0]  REG_CRITICAL     = 3'd3;
    localparam logic [2:0]  REG_LOW          = 3'd4;

    // register reset values
    localparam logic [15:0] RST_SCALE_NUM    = 16'd133;
    localparam logic [15:0] RST_SCALE_DEN    = 16'd33;
    localparam logic [15:0] RST_CHARGE_START = 16'd4000;
    localparam logic [15:0] RST_CRITICAL     = 16'd3300;
    localparam logic [15:0] RST_LOW          = 16'd3500;

    // default startup grace, in valid samples
    localparam int          DEF_STARTUP_SAMPLES = 10;

    // queue between front and back
    localparam int          QUEUE_DEPTH = 2;

    // fixed supervision constants
    localparam logic [15:0] IMPLAUSIBLE_MV     = 16'd2500;
    localparam logic [7:0]  STREAK_MIN         = 8'd3;
    localparam int          CHARGE_MIN_SAMPLES = 2;
    localparam logic [6:0]  PCT_STEP           = 7'd10;
    localparam logic [6:0]  PCT_FULL           = 7'd100;
    localparam logic [31:0] ARM_DELAY_MS       = 32'd2000;
    localparam logic [7:0]  STREAK_MAX         = 8'd255;
    localparam logic [15:0] MV_MAX             = 16'hFFFF;
    localparam logic [15:0] OCV_FIRST          = 16'd3000;
    localparam logic [15:0] OCV_LAST           = 16'd4200;

    // battery state codes
    localparam logic [2:0]  BST_NORMAL   = 3'd0;
    localparam logic [2:0]  BST_LOW      = 3'd1;
    localparam logic [2:0]  BST_CRITICAL = 3'd2;
    localparam logic [2:0]  BST_CHARGING = 3'd3;
    localparam logic [2:0]  BST_FULL     = 3'd4;

    // one classified tick
    typedef struct packed {
        logic        usb;
        logic        chg;
        logic        done;
        logic        valid;
        logic [11:0] pin_mv;
        logic [31:0] now_ms;
    } tick_t;

    // configuration registers
    typedef struct packed {
        logic [15:0] scale_num;
        logic [15:0] scale_den;
        logic [15:0] charge_start_mv;
        logic [15:0] critical_mv;
        logic [15:0] low_mv;
    } cfg_t;

    // open-circuit voltage table, 10 % apart
    function automatic logic [15:0] ocv_point(input logic [3:0] idx);
        logic [15:0] pt;
        unique case (idx)
            4'd0:    pt = 16'd3000;
            4'd1:    pt = 16'd3300;
            4'd2:    pt = 16'd3500;
            4'd3:    pt = 16'd3600;
            4'd4:    pt = 16'd3650;
            4'd5:    pt = 16'd3700;
            4'd6:    pt = 16'd3750;
            4'd7:    pt = 16'd3800;
            4'd8:    pt = 16'd3870;
            4'd9:    pt = 16'd3980;
            default: pt = 16'd4200;
        endcase
        return pt;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bsup_front.sv =====
// front end: accepts ticks and decodes the charger pins into a word
`timescale 1ns / 1ps
`default_nettype none

module bsup_front
    import bsup_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_usb_present,
    input  wire logic        s_charging_line_n,
    input  wire logic        s_done_line_n,
    input  wire logic        s_sample_valid,
    input  wire logic [11:0] s_adc_pin_mv,
    input  wire logic [31:0] s_now_ms,
    input  wire logic        q_full,
    output logic             q_push,
    output tick_t            q_word
);

    // take a word whenever the queue has room
    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready;

    // charger lines only count with usb present
    always_comb begin
        q_word.usb    = s_usb_present;
        q_word.chg    = s_usb_present && !s_charging_line_n;
        q_word.done   = s_usb_present && !s_done_line_n;
        q_word.valid  = s_sample_valid;
        q_word.pin_mv = s_adc_pin_mv;
        q_word.now_ms = s_now_ms;
    end

    // aclk and aresetn kept for a uniform header; no state here
    logic unused_ok;
    assign unused_ok = aclk & aresetn;

endmodule

`default_nettype wire

// ===== hw/rtl/bsup_queue.sv =====
// short queue of classified ticks between front and back
`timescale 1ns / 1ps
`default_nettype none

module bsup_queue
    import bsup_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push,
    input  wire tick_t push_word,
    output logic       full,
    input  wire logic  pop,
    output logic       not_empty,
    output tick_t      head_word
);

`include "battery_supervisor_top_assert.svh"

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    tick_t            slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign head_word = slot_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `BSUP_ASSERT_IMP(ast_no_overflow, push, !full, "queue written while full")
    `BSUP_ASSERT_IMP(ast_no_underflow, pop, not_empty, "queue read while empty")
    `BSUP_ASSERT_NEXT(ast_count_up, push && !pop, count_reg == $past(count_reg) + 1'b1, "queue count did not rise on a lone write")

endmodule

`default_nettype wire

// ===== hw/rtl/bsup_core.sv =====
// back end: scaling, state of charge, classification and shutdown timer
`timescale 1ns / 1ps
`default_nettype none

module bsup_core
    import bsup_pkg::*;
#(
    parameter int STARTUP_SAMPLES = DEF_STARTUP_SAMPLES
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire cfg_t        cfg,
    input  wire logic        q_not_empty,
    input  wire tick_t       q_head,
    output logic             q_pop,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_battery_state,
    output logic [6:0]       m_charge_percent,
    output logic [15:0]      m_battery_mv,
    output logic             m_charging_flag,
    output logic             m_usb_flag,
    output logic             m_charge_enable,
    output logic             m_low_flag,
    output logic             m_critical_flag,
    output logic             m_shutdown_request
);

`include "battery_supervisor_top_assert.svh"

    localparam int VC_W = $clog2(STARTUP_SAMPLES + 1);
    localparam logic [VC_W-1:0] VC_FULL   = VC_W'(STARTUP_SAMPLES);
    localparam logic [VC_W-1:0] VC_CHARGE = VC_W'(CHARGE_MIN_SAMPLES);

    // sequencer codes
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_PCT  = 3'd4;
    localparam logic [2:0] S_SCAN = 3'd5;
    localparam logic [2:0] S_PDIV = 3'd6;
    localparam logic [2:0] S_UPD  = 3'd7;

    logic [2:0]      state_reg;
    tick_t           tick_reg;
    logic [27:0]     prod_reg;
    logic [15:0]     rem_reg;
    logic [15:0]     quo_reg;
    logic [3:0]      cnt_reg;
    logic [3:0]      seg_reg;
    logic [15:0]     mv_new_reg;
    logic [6:0]      pct_new_reg;

    // supervision state
    logic [15:0]     held_mv_reg;
    logic [6:0]      held_pct_reg;
    logic [VC_W-1:0] valid_count_reg;
    logic            charge_latch_reg;
    logic [7:0]      critical_run_reg;
    logic            shutdown_armed_reg;
    logic [31:0]     arm_time_reg;

    // output word
    logic            m_valid_reg;
    logic [2:0]      out_state_reg;
    logic [6:0]      out_pct_reg;
    logic [15:0]     out_mv_reg;
    logic            out_chg_reg;
    logic            out_usb_reg;
    logic            out_latch_reg;
    logic            out_low_reg;
    logic            out_crit_reg;
    logic            out_req_reg;

    // shared restoring divider step: one quotient bit a cycle
    logic [15:0] divisor;
    logic [16:0] rem_shift;
    logic        quo_bit;
    logic [16:0] rem_diff;
    logic [15:0] rem_step;
    logic [15:0] quo_step;

    // table segment under scan
    logic [3:0]  seg_prev;
    logic [15:0] seg_lo;
    logic [15:0] seg_hi;
    logic [15:0] seg_span;
    logic [15:0] seg_off;
    logic [11:0] pct_dividend;

    assign seg_prev     = seg_reg - 4'd1;
    assign seg_lo       = ocv_point(seg_prev);
    assign seg_hi       = ocv_point(seg_reg);
    assign seg_span     = seg_hi - seg_lo;
    assign seg_off      = mv_new_reg - seg_lo;
    // widest segment is 300 mv, so the offset needs nine bits
    assign pct_dividend = 12'({3'b0, seg_off[8:0]} << 3) + 12'({3'b0, seg_off[8:0]} << 1);

    assign divisor   = (state_reg == S_PDIV) ? seg_span : cfg.scale_den;
    assign rem_shift = {rem_reg, quo_reg[15]};
    assign quo_bit   = (rem_shift >= {1'b0, divisor});
    assign rem_diff  = rem_shift - {1'b0, divisor};
    assign rem_step  = quo_bit ? rem_diff[15:0] : rem_shift[15:0];
    assign quo_step  = {quo_reg[14:0], quo_bit};

    // tick update, evaluated in the update state
    logic            out_free;
    logic [15:0]     mv_eff;
    logic [6:0]      pct_eff;
    logic [VC_W-1:0] vc_next;
    logic            latch_next;
    logic [2:0]      bst_next;
    logic            real_crit;
    logic [7:0]      run_next;
    logic            armed_next;
    logic [31:0]     arm_time_next;
    logic            req_next;
    logic [31:0]     elapsed;

    assign out_free = !m_valid_reg || m_ready;
    assign elapsed  = tick_reg.now_ms - arm_time_reg;

    always_comb begin
        mv_eff  = tick_reg.valid ? mv_new_reg  : held_mv_reg;
        pct_eff = tick_reg.valid ? pct_new_reg : held_pct_reg;
        vc_next = valid_count_reg;
        if (tick_reg.valid && (valid_count_reg < VC_FULL)) begin
            vc_next = valid_count_reg + 1'b1;
        end

        // charge enable latch
        latch_next = charge_latch_reg;
        if (!tick_reg.usb || tick_reg.done) begin
            latch_next = 1'b0;
        end else if ((vc_next >= VC_CHARGE) && (mv_eff != '0) &&
                     (mv_eff < cfg.charge_start_mv)) begin
            latch_next = 1'b1;
        end

        // classification with startup grace
        if (vc_next < VC_FULL) begin
            bst_next = BST_NORMAL;
        end else if (tick_reg.usb) begin
            if (tick_reg.done) begin
                bst_next = BST_FULL;
            end else if (tick_reg.chg || latch_next) begin
                bst_next = BST_CHARGING;
            end else begin
                bst_next = BST_NORMAL;
            end
        end else if ((mv_eff == '0) || (mv_eff < cfg.critical_mv)) begin
            bst_next = BST_CRITICAL;
        end else if (mv_eff < cfg.low_mv) begin
            bst_next = BST_LOW;
        end else begin
            bst_next = BST_NORMAL;
        end

        // plausible critical streak
        real_crit = (bst_next == BST_CRITICAL) && (mv_eff >= IMPLAUSIBLE_MV) &&
                    (mv_eff < cfg.critical_mv);
        if (real_crit) begin
            run_next = (critical_run_reg < STREAK_MAX) ? critical_run_reg + 8'd1
                                                       : critical_run_reg;
        end else begin
            run_next = '0;
        end

        // shutdown timer
        armed_next    = shutdown_armed_reg;
        arm_time_next = arm_time_reg;
        req_next      = 1'b0;
        if ((run_next >= STREAK_MIN) && !tick_reg.usb) begin
            if (!shutdown_armed_reg) begin
                armed_next    = 1'b1;
                arm_time_next = tick_reg.now_ms;
            end else if (elapsed >= ARM_DELAY_MS) begin
                req_next = 1'b1;
            end
        end else begin
            armed_next = 1'b0;
        end
    end

    assign q_pop = (state_reg == S_IDLE) && q_not_empty;

    // sequencer and datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= S_IDLE;
            held_mv_reg        <= '0;
            held_pct_reg       <= '0;
            valid_count_reg    <= '0;
            charge_latch_reg   <= 1'b0;
            critical_run_reg   <= '0;
            shutdown_armed_reg <= 1'b0;
            arm_time_reg       <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (q_not_empty) begin
                        tick_reg  <= q_head;
                        state_reg <= q_head.valid ? S_MUL : S_UPD;
                    end
                end
                S_MUL: begin
                    prod_reg  <= {16'b0, tick_reg.pin_mv} * {12'b0, cfg.scale_num};
                    state_reg <= S_CHK;
                end
                S_CHK: begin
                    // quotient of 2^16 or more, or a zero denominator, saturates
                    if ({4'b0, prod_reg} >= {cfg.scale_den, 16'b0}) begin
                        mv_new_reg <= MV_MAX;
                        state_reg  <= S_PCT;
                    end else begin
                        rem_reg   <= {4'b0, prod_reg[27:16]};
                        quo_reg   <= prod_reg[15:0];
                        cnt_reg   <= 4'd15;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    rem_reg <= rem_step;
                    quo_reg <= quo_step;
                    cnt_reg <= cnt_reg - 4'd1;
                    if (cnt_reg == '0) begin
                        mv_new_reg <= quo_step;
                        state_reg  <= S_PCT;
                    end
                end
                S_PCT: begin
                    if (mv_new_reg <= OCV_FIRST) begin
                        pct_new_reg <= '0;
                        state_reg   <= S_UPD;
                    end else if (mv_new_reg >= OCV_LAST) begin
                        pct_new_reg <= PCT_FULL;
                        state_reg   <= S_UPD;
                    end else begin
                        seg_reg   <= 4'd1;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (mv_new_reg < seg_hi) begin
                        rem_reg   <= '0;
                        quo_reg   <= {pct_dividend, 4'b0};
                        cnt_reg   <= 4'd11;
                        state_reg <= S_PDIV;
                    end else begin
                        seg_reg <= seg_reg + 4'd1;
                    end
                end
                S_PDIV: begin
                    rem_reg <= rem_step;
                    quo_reg <= quo_step;
                    cnt_reg <= cnt_reg - 4'd1;
                    if (cnt_reg == '0) begin
                        pct_new_reg <= 7'({3'b0, seg_prev} * PCT_STEP) + {3'b0, quo_step[3:0]};
                        state_reg   <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (out_free) begin
                        held_mv_reg        <= mv_eff;
                        held_pct_reg       <= pct_eff;
                        valid_count_reg    <= vc_next;
                        charge_latch_reg   <= latch_next;
                        critical_run_reg   <= run_next;
                        shutdown_armed_reg <= armed_next;
                        arm_time_reg       <= arm_time_next;
                        state_reg          <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // result valid: set with the state update, cleared when the word is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == S_UPD) && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result word, loaded with the state update
    always_ff @(posedge aclk) begin
        if ((state_reg == S_UPD) && out_free) begin
            out_state_reg <= bst_next;
            out_pct_reg   <= pct_eff;
            out_mv_reg    <= mv_eff;
            out_chg_reg   <= tick_reg.chg;
            out_usb_reg   <= tick_reg.usb;
            out_latch_reg <= latch_next;
            out_low_reg   <= (bst_next == BST_LOW) || (bst_next == BST_CRITICAL);
            out_crit_reg  <= (bst_next == BST_CRITICAL);
            out_req_reg   <= req_next;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_battery_state    = out_state_reg;
    assign m_charge_percent   = out_pct_reg;
    assign m_battery_mv       = out_mv_reg;
    assign m_charging_flag    = out_chg_reg;
    assign m_usb_flag         = out_usb_reg;
    assign m_charge_enable    = out_latch_reg;
    assign m_low_flag         = out_low_reg;
    assign m_critical_flag    = out_crit_reg;
    assign m_shutdown_request = out_req_reg;

    `BSUP_ASSERT_IMP(ast_armed_streak, shutdown_armed_reg, critical_run_reg >= STREAK_MIN, "shutdown armed without a critical streak")
    `BSUP_ASSERT_IMP(ast_count_limit, 1'b1, valid_count_reg <= VC_FULL, "valid sample count past its limit")
    `BSUP_ASSERT_IMP(ast_req_armed, m_valid_reg && out_req_reg, shutdown_armed_reg, "shutdown request shown while disarmed")

endmodule

`default_nettype wire

// ===== hw/rtl/battery_supervisor_top.sv =====
// top level of the battery supervisor: configuration registers and wiring
//
//  channel  direction  handshake          payload
//  s_       in         s_valid / s_ready  pin levels, sample flag, adc mv, time ms
//  m_       out        m_valid / m_ready  state, percent, mv, flags, shutdown
//  cfg_     in         cfg_wr_en          register index, 16-bit data
//
// a tick without a sample goes straight to the update state in the back end;
// with a sample it runs at most a 16-step restoring divider for the voltage,
// a table scan of up to 10 steps and a 12-step pass of that divider for percent.
// reset is synchronous, active low, and loads the register defaults.
// a two-word queue lets the input keep taking words while the back end works,
// and the result register holds a word until m_ready takes it.
`timescale 1ns / 1ps
`default_nettype none

module battery_supervisor_top
    import bsup_pkg::*;
#(
    parameter int STARTUP_SAMPLES = DEF_STARTUP_SAMPLES
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_usb_present,
    input  wire logic                  s_charging_line_n,
    input  wire logic                  s_done_line_n,
    input  wire logic                  s_sample_valid,
    input  wire logic [11:0]           s_adc_pin_mv,
    input  wire logic [31:0]           s_now_ms,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [2:0]                 m_battery_state,
    output logic [6:0]                 m_charge_percent,
    output logic [15:0]                m_battery_mv,
    output logic                       m_charging_flag,
    output logic                       m_usb_flag,
    output logic                       m_charge_enable,
    output logic                       m_low_flag,
    output logic                       m_critical_flag,
    output logic                       m_shutdown_request
);

    cfg_t  cfg_reg;
    logic  q_full;
    logic  q_push;
    tick_t q_word;
    logic  q_pop;
    logic  q_not_empty;
    tick_t q_head;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.scale_num       <= RST_SCALE_NUM;
            cfg_reg.scale_den       <= RST_SCALE_DEN;
            cfg_reg.charge_start_mv <= RST_CHARGE_START;
            cfg_reg.critical_mv     <= RST_CRITICAL;
            cfg_reg.low_mv          <= RST_LOW;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_SCALE_NUM:    cfg_reg.scale_num       <= cfg_wr_data;
                REG_SCALE_DEN:    cfg_reg.scale_den       <= cfg_wr_data;
                REG_CHARGE_START: cfg_reg.charge_start_mv <= cfg_wr_data;
                REG_CRITICAL:     cfg_reg.critical_mv     <= cfg_wr_data;
                REG_LOW:          cfg_reg.low_mv          <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // front end
    bsup_front u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_usb_present     (s_usb_present),
        .s_charging_line_n (s_charging_line_n),
        .s_done_line_n     (s_done_line_n),
        .s_sample_valid    (s_sample_valid),
        .s_adc_pin_mv      (s_adc_pin_mv),
        .s_now_ms          (s_now_ms),
        .q_full            (q_full),
        .q_push            (q_push),
        .q_word            (q_word)
    );

    // word queue
    bsup_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_word (q_word),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_word (q_head)
    );

    // back end
    bsup_core #(
        .STARTUP_SAMPLES (STARTUP_SAMPLES)
    ) u_core (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg                (cfg_reg),
        .q_not_empty        (q_not_empty),
        .q_head             (q_head),
        .q_pop              (q_pop),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_battery_state    (m_battery_state),
        .m_charge_percent   (m_charge_percent),
        .m_battery_mv       (m_battery_mv),
        .m_charging_flag    (m_charging_flag),
        .m_usb_flag         (m_usb_flag),
        .m_charge_enable    (m_charge_enable),
        .m_low_flag         (m_low_flag),
        .m_critical_flag    (m_critical_flag),
        .m_shutdown_request (m_shutdown_request)
    );

endmodule

`default_nettype wire
